### rtl/core/nca_pkg.sv
// nca_pkg: shared types and constants for the nearest centroid assignment block
// used by nca_cell and nearest_centroid_assign_unit; no dependencies
`timescale 1ns / 1ps

package nca_pkg;

  localparam int NUM_CELLS = 16;
  localparam int DEPTH     = 16;
  localparam int IDX_W     = 4;
  localparam int EIDX_W    = 4;
  localparam int VAL_W     = 16;
  localparam int DIST_W    = 36;
  localparam int CNT_W     = 16;
  localparam int REG_W     = 5;
  localparam int CMD_W     = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DATA  = 2'd2;

  localparam logic REG_CLUSTER_COUNT = 1'b0;
  localparam logic REG_DIMENSION     = 1'b1;

  localparam logic [DIST_W-1:0] DIST_MAX  = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
  localparam logic [REG_W-1:0]  K_LIMIT   = REG_W'(NUM_CELLS);
  localparam logic [REG_W-1:0]  D_LIMIT   = REG_W'(DEPTH);

  typedef struct packed {
    logic                     valid;
    logic [CMD_W-1:0]         cmd;
    logic [IDX_W-1:0]         ci;
    logic [EIDX_W-1:0]        ei;
    logic signed [VAL_W-1:0]  value;
    logic                     last;
    logic [REG_W-1:0]         kk;
    logic [IDX_W-1:0]         best_idx;
    logic [DIST_W-1:0]        best_d;
  } tok_t;

endpackage

### rtl/core/nearest_centroid_assign_unit.sv
// nearest_centroid_assign_unit: k-means assignment step built as a chain of centroid cells
// depends on nca_pkg and nca_cell
//
// usage:
//   in_* stream carries load, start and data transactions (in_tuser selects the kind).
//   load writes one element of one centroid; start clears member counts, the point
//   counter and partial distances; data brings one element of a point.
//   every transaction walks the 16 cells, one cell per cycle unless stalled; each cell
//   squares the difference against its centroid element and accumulates, and on the
//   last element of a point keeps a running minimum that travels with the transaction.
//   a result shows on out_* once the data transaction that ends the point has passed
//   the 16 cell stages and been captured in the output register.
//   throughput: one transaction per cycle while in_tready is high, set by the chain.
//   out_* stalls hold the output register; the chain keeps accepting until a result
//   reaches its tail while the output register is full, then in_tready drops.
//   reset (rst_n low, synchronous): empties the chain and output, zeroes partial
//   distances, member counts and the point counter, sets both config registers to 1.
//   centroid elements are not reset and must be loaded before use.
//   cfg_* writes must happen only while the chain is empty.
`timescale 1ns / 1ps

module nearest_centroid_assign_unit import nca_pkg::*; #(
  parameter int MAX_POINTS = 65536
) (
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  // input stream
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [23:0]      in_tdata,   // centroid_index[3:0], element_index[7:4], value[23:8]
  input  logic [CMD_W-1:0] in_tuser,   // command[1:0]
  // result stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [71:0]      out_tdata   // point_index[15:0], cluster[19:16], slot[35:20],
                                       // distance_squared[71:36]
);

  localparam int PC_W = $clog2(MAX_POINTS);
  localparam logic [PC_W-1:0] PC_MAX = PC_W'(MAX_POINTS - 1);

  logic [REG_W-1:0] cluster_count_r, dimension_r;
  logic [REG_W-1:0] k_eff, d_eff;

  tok_t tok_chain [NUM_CELLS+1];
  tok_t tail;
  logic adv, tail_res, tail_start;

  logic [CNT_W-1:0] cnt_r [NUM_CELLS];
  logic [CNT_W-1:0] cnt_sel;
  logic [PC_W-1:0]  pc_r;
  logic [31:0]      pc_ext;

  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_pidx_r;
  logic [IDX_W-1:0]  out_cl_r;
  logic [CNT_W-1:0]  out_slot_r;
  logic [DIST_W-1:0] out_dist_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cluster_count_r <= REG_W'(1);
      dimension_r     <= REG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CLUSTER_COUNT: cluster_count_r <= cfg_data;
        REG_DIMENSION:     dimension_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    k_eff = (cluster_count_r == '0) ? REG_W'(1) :
            (cluster_count_r > K_LIMIT) ? K_LIMIT : cluster_count_r;
    d_eff = (dimension_r == '0) ? REG_W'(1) :
            (dimension_r > D_LIMIT) ? D_LIMIT : dimension_r;
  end

  // chain entry
  assign tail       = tok_chain[NUM_CELLS];
  assign tail_res   = tail.valid && (tail.cmd == CMD_DATA) && tail.last;
  assign tail_start = tail.valid && (tail.cmd == CMD_START);
  assign adv        = !(tail_res && out_valid_r && !out_tready);
  assign in_tready  = adv;

  always_comb begin
    tok_chain[0].valid    = in_tvalid && in_tready;
    tok_chain[0].cmd      = in_tuser;
    tok_chain[0].ci       = in_tdata[3:0];
    tok_chain[0].ei       = in_tdata[7:4];
    tok_chain[0].value    = in_tdata[23:8];
    tok_chain[0].last     = ({1'b0, in_tdata[7:4]} == (d_eff - REG_W'(1)));
    tok_chain[0].kk       = k_eff;
    tok_chain[0].best_idx = '0;
    tok_chain[0].best_d   = DIST_MAX;
  end

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    nca_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_idx (IDX_W'(g)),
      .tok_i    (tok_chain[g]),
      .tok_o    (tok_chain[g+1])
    );
  end

  // member counts and point counter at the chain tail
  assign cnt_sel = cnt_r[tail.best_idx];
  assign pc_ext  = 32'(pc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CELLS; i++) begin
        cnt_r[i] <= '0;
      end
      pc_r <= '0;
    end else if (adv && tail_start) begin
      for (int i = 0; i < NUM_CELLS; i++) begin
        cnt_r[i] <= '0;
      end
      pc_r <= '0;
    end else if (adv && tail_res) begin
      if (cnt_sel != CNT_MAX) begin
        cnt_r[tail.best_idx] <= cnt_sel + CNT_W'(1);
      end
      if (pc_r != PC_MAX) begin
        pc_r <= pc_r + PC_W'(1);
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv && tail_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tail_res) begin
      out_pidx_r <= pc_ext[15:0];
      out_cl_r   <= tail.best_idx;
      out_slot_r <= cnt_sel;
      out_dist_r <= tail.best_d;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_dist_r, out_slot_r, out_cl_r, out_pidx_r};

  // checks
  a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_valid_r && !out_tready && tail_res))
    else $error("input stalled without a blocked result");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && tail_res) |=> (out_valid_r && (out_cl_r == $past(tail.best_idx))))
    else $error("result not captured in output register");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && tail_start) |=> ((pc_r == '0) && (cnt_r[0] == '0)))
    else $error("start transaction did not clear counters");

  a_tail_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(tail))
    else $error("chain moved while stalled");

endmodule

### rtl/core/nca_cell.sv
// nca_cell: one centroid cell of the chain, holds its centroid vector and partial distance
// depends on nca_pkg
`timescale 1ns / 1ps

module nca_cell import nca_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [IDX_W-1:0] cell_idx,
  input  tok_t             tok_i,
  output tok_t             tok_o
);

  logic signed [VAL_W-1:0] cent_r [DEPTH];
  logic [DIST_W-1:0]       partial_r, partial_nxt;
  tok_t                    tok_r, tok_nxt;

  logic                    active;
  logic signed [VAL_W-1:0] cent_rd;
  logic signed [VAL_W:0]   diff;
  logic [VAL_W:0]          neg;
  logic [VAL_W-1:0]        mag;
  logic [2*VAL_W-1:0]      sq;
  logic [DIST_W:0]         sum;
  logic [DIST_W-1:0]       sum_sat;

  always_comb begin
    active  = {1'b0, cell_idx} < tok_i.kk;
    cent_rd = cent_r[tok_i.ei];
    diff    = {tok_i.value[VAL_W-1], tok_i.value} - {cent_rd[VAL_W-1], cent_rd};
    neg     = -diff;
    mag     = diff[VAL_W] ? neg[VAL_W-1:0] : diff[VAL_W-1:0];
    sq      = mag * mag;
    sum     = (DIST_W+1)'(partial_r) + (DIST_W+1)'(sq);
    sum_sat = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

    partial_nxt = partial_r;
    tok_nxt     = tok_i;
    if (tok_i.valid) begin
      unique case (tok_i.cmd)
        CMD_START: begin
          partial_nxt = '0;
        end
        CMD_DATA: begin
          if (tok_i.last) begin
            // the end of a point clears every cell, in use or not
            partial_nxt = '0;
            if (active && (sum_sat < tok_i.best_d)) begin
              tok_nxt.best_d   = sum_sat;
              tok_nxt.best_idx = cell_idx;
            end
          end else if (active) begin
            partial_nxt = sum_sat;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r     <= '0;
      partial_r <= '0;
    end else if (adv) begin
      tok_r     <= tok_nxt;
      partial_r <= partial_nxt;
    end
  end

  // centroid elements, written by load transactions addressed to this cell
  always_ff @(posedge clk) begin
    if (adv && tok_i.valid && (tok_i.cmd == CMD_LOAD) && (tok_i.ci == cell_idx)) begin
      cent_r[tok_i.ei] <= tok_i.value;
    end
  end

  assign tok_o = tok_r;

endmodule
